[hdl/ttp_pkg.sv]
package ttp_pkg;

    // Angle wrap constants, Q16.16
    localparam logic [19:0] PI_Q16     = 20'd205887;
    localparam logic [32:0] TWO_PI_Q16 = 33'd411774;
    // PI plus a multiple of two pi that lifts any 32-bit distance above zero
    localparam logic [33:0] WRAP_OFFSET = 34'd2148019071;
    localparam int WRAP_STEPS     = 14;
    localparam int WRAP_PER_STAGE = 2;
    localparam int WRAP_STAGES    = WRAP_STEPS / WRAP_PER_STAGE;

    localparam logic [31:0] MAX32       = 32'hFFFF_FFFF;
    localparam logic [31:0] LIMIT_RESET = 32'd65536;

    // Default step counts of the iterative units
    localparam int DIV_STEPS_DEF  = 4;
    localparam int SQRT_STEPS_DEF = 4;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx REG_ACCEL = 1'b0;
    localparam t_cfg_idx REG_SPEED = 1'b1;

    // Plan data riding along the final divide
    typedef struct packed {
        logic        trap;
        logic [31:0] ramp;
    } t_plan_side;

    // Plan data riding along the square root
    typedef struct packed {
        logic        trap;
        logic [31:0] ramp;
        logic [31:0] run;
    } t_root_side;

endpackage

[hdl/ttp_div.sv]
module ttp_div import ttp_pkg::*; #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 32,
    parameter int STEPS  = DIV_STEPS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);

    localparam int NSTG = NUM_W / STEPS;

    // Numerator bits shift out the top while quotient bits shift in the bottom
    logic              r_valid [NSTG];
    logic [NUM_W-1:0]  r_acc   [NSTG];
    logic [DEN_W-1:0]  r_rem   [NSTG];
    logic [DEN_W-1:0]  r_den   [NSTG];
    logic [SIDE_W-1:0] r_side  [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic              in_valid;
        logic [NUM_W-1:0]  in_acc;
        logic [DEN_W-1:0]  in_rem;
        logic [DEN_W-1:0]  in_den;
        logic [SIDE_W-1:0] in_side;
        logic [NUM_W-1:0]  n_acc;
        logic [DEN_W-1:0]  n_rem;
        logic [DEN_W:0]    t;

        if (s == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_acc   = i_num;
            assign in_rem   = '0;
            assign in_den   = i_den;
            assign in_side  = i_side;
        end else begin : g_next
            assign in_valid = r_valid[s-1];
            assign in_acc   = r_acc[s-1];
            assign in_rem   = r_rem[s-1];
            assign in_den   = r_den[s-1];
            assign in_side  = r_side[s-1];
        end

        // Restoring divide, one quotient bit per step
        always_comb begin
            n_acc = in_acc;
            n_rem = in_rem;
            t     = '0;
            for (int k = 0; k < STEPS; k++) begin
                t     = {n_rem, n_acc[NUM_W-1]};
                n_acc = {n_acc[NUM_W-2:0], 1'b0};
                if (t >= {1'b0, in_den}) begin
                    t        = t - {1'b0, in_den};
                    n_acc[0] = 1'b1;
                end
                n_rem = t[DEN_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_acc[s]  <= n_acc;
            r_rem[s]  <= n_rem;
            r_den[s]  <= in_den;
            r_side[s] <= in_side;
        end
    end

    assign o_valid = r_valid[NSTG-1];
    assign o_quot  = r_acc[NSTG-1];
    assign o_side  = r_side[NSTG-1];

endmodule

[hdl/ttp_sqrt.sv]
module ttp_sqrt import ttp_pkg::*; #(
    parameter int RAD_W  = 64,
    parameter int STEPS  = SQRT_STEPS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [RAD_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [RAD_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]    o_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int NSTG   = ROOT_W / STEPS;

    logic              r_valid [NSTG];
    logic [RAD_W-1:0]  r_rad   [NSTG];
    logic [REM_W-1:0]  r_rem   [NSTG];
    logic [ROOT_W-1:0] r_root  [NSTG];
    logic [SIDE_W-1:0] r_side  [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic              in_valid;
        logic [RAD_W-1:0]  in_rad;
        logic [REM_W-1:0]  in_rem;
        logic [ROOT_W-1:0] in_root;
        logic [SIDE_W-1:0] in_side;
        logic [RAD_W-1:0]  n_rad;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;
        logic [REM_W+1:0]  t;
        logic [ROOT_W+1:0] trial;

        if (s == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_rad   = i_rad;
            assign in_rem   = '0;
            assign in_root  = '0;
            assign in_side  = i_side;
        end else begin : g_next
            assign in_valid = r_valid[s-1];
            assign in_rad   = r_rad[s-1];
            assign in_rem   = r_rem[s-1];
            assign in_root  = r_root[s-1];
            assign in_side  = r_side[s-1];
        end

        // Digit-by-digit root, one result bit per step
        always_comb begin
            n_rad  = in_rad;
            n_rem  = in_rem;
            n_root = in_root;
            t      = '0;
            trial  = '0;
            for (int k = 0; k < STEPS; k++) begin
                t     = {n_rem, n_rad[RAD_W-1:RAD_W-2]};
                n_rad = {n_rad[RAD_W-3:0], 2'b00};
                trial = {n_root, 2'b01};
                if (t >= {1'b0, trial}) begin
                    t      = t - {1'b0, trial};
                    n_root = {n_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_root = {n_root[ROOT_W-2:0], 1'b0};
                end
                n_rem = t[REM_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[s]  <= n_rad;
            r_rem[s]  <= n_rem;
            r_root[s] <= n_root;
            r_side[s] <= in_side;
        end
    end

    assign o_valid = r_valid[NSTG-1];
    assign o_root  = r_root[NSTG-1];
    assign o_side  = r_side[NSTG-1];

endmodule

[hdl/trapezoid_time_planner.sv]
// Built from the entry stage, the angle wrap stages, two pipelined restoring dividers and a
// pipelined square root, with registered product and select stages and a result register.
// Throughput: one request per cycle; busy never rises and the result receiver cannot stall.
// Reset (synchronous, active low) empties the pipeline and sets both limits to 1.0;
// no result strobe appears until a request transfers after reset.
module trapezoid_time_planner import ttp_pkg::*; #(
    parameter int DIV_STEPS  = DIV_STEPS_DEF,
    parameter int SQRT_STEPS = SQRT_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_is_angle,
    input  logic signed [31:0] i_distance,
    output logic               o_valid,
    output logic [31:0]        o_ramp_time,
    output logic [31:0]        o_run_time,
    output logic               o_reaches_top_speed
);

    localparam int LAT = 3 + WRAP_STAGES + 48 / DIV_STEPS + 4 + 64 / DIV_STEPS
                         + 32 / SQRT_STEPS;

    logic [31:0] r_accel;
    logic [31:0] r_speed;

    // Every request is accepted at once
    assign busy = 1'b0;

    // Limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= LIMIT_RESET;
            r_speed <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ACCEL: r_accel <= i_cfg_data;
                REG_SPEED: r_speed <= i_cfg_data;
                default:   r_accel <= r_accel;
            endcase
        end
    end

    // Entry stage: bias distance so the wrap works on a positive value
    logic        r_iv;
    logic [32:0] r_iy;
    logic        r_ia;
    logic [31:0] r_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else begin
            r_iv <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iy <= 33'({{2{i_distance[31]}}, i_distance} + WRAP_OFFSET);
        r_ia <= i_is_angle;
        r_id <= i_distance;
    end

    // Wrap stages: reduce modulo two pi by shifted compare and subtract
    logic        r_wv [WRAP_STAGES];
    logic [32:0] r_wy [WRAP_STAGES];
    logic        r_wa [WRAP_STAGES];
    logic [31:0] r_wd [WRAP_STAGES];

    for (genvar s = 0; s < WRAP_STAGES; s++) begin : g_wrap
        logic        in_v;
        logic [32:0] in_y;
        logic        in_a;
        logic [31:0] in_d;
        logic [32:0] n_y;
        logic [32:0] sub;

        if (s == 0) begin : g_first
            assign in_v = r_iv;
            assign in_y = r_iy;
            assign in_a = r_ia;
            assign in_d = r_id;
        end else begin : g_next
            assign in_v = r_wv[s-1];
            assign in_y = r_wy[s-1];
            assign in_a = r_wa[s-1];
            assign in_d = r_wd[s-1];
        end

        always_comb begin
            n_y = in_y;
            sub = '0;
            for (int k = 0; k < WRAP_PER_STAGE; k++) begin
                sub = TWO_PI_Q16 << (WRAP_STEPS - 1 - WRAP_PER_STAGE * s - k);
                if (n_y >= sub) begin
                    n_y = n_y - sub;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_wv[s] <= 1'b0;
            end else begin
                r_wv[s] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_wy[s] <= n_y;
            r_wa[s] <= in_a;
            r_wd[s] <= in_d;
        end
    end

    // Magnitude stage
    logic        r_mv;
    logic [31:0] r_m;
    logic [31:0] wrapped;
    logic [31:0] chosen;

    always_comb begin
        wrapped = r_wy[WRAP_STAGES-1][31:0] - {12'd0, PI_Q16};
        chosen  = r_wa[WRAP_STAGES-1] ? wrapped : r_wd[WRAP_STAGES-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= r_wv[WRAP_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= chosen[31] ? (32'd0 - chosen) : chosen;
    end

    // Ramp time divide: v * 2^16 / a, magnitude rides along
    logic        rd_valid;
    logic [47:0] rd_quot;
    logic [31:0] rd_m;

    ttp_div #(
        .NUM_W  (48),
        .DEN_W  (32),
        .STEPS  (DIV_STEPS),
        .SIDE_W (32)
    ) u_ramp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_mv),
        .i_num   ({r_speed, 16'd0}),
        .i_den   (r_accel),
        .i_side  (r_m),
        .o_valid (rd_valid),
        .o_quot  (rd_quot),
        .o_side  (rd_m)
    );

    // Saturate ramp time
    logic        r_r0v;
    logic [31:0] r_r0;
    logic [31:0] r_r0m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r0v <= 1'b0;
        end else begin
            r_r0v <= rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r0  <= (rd_quot[47:32] != 16'd0) ? MAX32 : rd_quot[31:0];
        r_r0m <= rd_m;
    end

    // Ramp distance, first product: a * r
    logic        r_m1v;
    logic [63:0] r_m1prod;
    logic [31:0] r_m1r;
    logic [31:0] r_m1m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1v <= 1'b0;
        end else begin
            r_m1v <= r_r0v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1prod <= {32'd0, r_accel} * {32'd0, r_r0};
        r_m1r    <= r_r0;
        r_m1m    <= r_r0m;
    end

    // Ramp distance, second product: p1 * r (a * r stays below 2^48)
    logic        r_m2v;
    logic [47:0] r_m2p2;
    logic [31:0] r_m2r;
    logic [31:0] r_m2m;
    logic [63:0] prod2;

    assign prod2 = {32'd0, r_m1prod[47:16]} * {32'd0, r_m1r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2v <= 1'b0;
        end else begin
            r_m2v <= r_m1v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m2p2 <= prod2[63:16];
        r_m2r  <= r_m1r;
        r_m2m  <= r_m1m;
    end

    // Pick the profile and the operands of the shared second divide
    logic        r_cv;
    logic [63:0] r_cnum;
    logic [31:0] r_cden;
    t_plan_side  r_cside;
    logic        trap;
    logic [47:0] run_dist;

    always_comb begin
        trap     = r_m2p2 <= {16'd0, r_m2m};
        run_dist = {16'd0, r_m2m} - r_m2p2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else begin
            r_cv <= r_m2v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnum       <= trap ? {16'd0, run_dist[31:0], 16'd0} : {r_m2m, 32'd0};
        r_cden       <= trap ? r_speed : r_accel;
        r_cside.trap <= trap;
        r_cside.ramp <= r_m2r;
    end

    // Run time or triangular ramp radicand
    logic        dd_valid;
    logic [63:0] dd_quot;
    t_plan_side  dd_side;
    t_root_side  sq_in_side;

    ttp_div #(
        .NUM_W  (64),
        .DEN_W  (32),
        .STEPS  (DIV_STEPS),
        .SIDE_W ($bits(t_plan_side))
    ) u_run_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_cv),
        .i_num   (r_cnum),
        .i_den   (r_cden),
        .i_side  (r_cside),
        .o_valid (dd_valid),
        .o_quot  (dd_quot),
        .o_side  (dd_side)
    );

    always_comb begin
        sq_in_side.trap = dd_side.trap;
        sq_in_side.ramp = dd_side.ramp;
        sq_in_side.run  = (dd_quot[63:32] != 32'd0) ? MAX32 : dd_quot[31:0];
    end

    // Square root for the triangular ramp
    logic        sq_valid;
    logic [31:0] sq_root;
    t_root_side  sq_side;

    ttp_sqrt #(
        .RAD_W  (64),
        .STEPS  (SQRT_STEPS),
        .SIDE_W ($bits(t_root_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dd_valid),
        .i_rad   (dd_quot),
        .i_side  (sq_in_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_ramp_time         <= sq_side.trap ? sq_side.ramp : sq_root;
        o_run_time          <= sq_side.trap ? sq_side.run : 32'd0;
        o_reaches_top_speed <= sq_side.trap;
    end

    // Every result strobe traces back to a transfer a fixed latency earlier
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching request");

    // Wrap leaves a remainder below two pi
    a_wrap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv[WRAP_STAGES-1] |-> r_wy[WRAP_STAGES-1] < TWO_PI_Q16)
        else $error("angle wrap out of range");

    // Triangular profile only arises with a nonzero acceleration limit
    a_tri_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv && !r_cside.trap |-> r_cden != 32'd0)
        else $error("triangular plan with zero acceleration");

endmodule
